FILE: rtl/dtes_pkg.sv
`default_nettype none

package dtes_pkg;

   localparam int unsigned YEAR_W  = 7;
   localparam int unsigned MONTH_W = 4;
   localparam int unsigned DAY_W   = 5;
   localparam int unsigned HOUR_W  = 5;
   localparam int unsigned MIN_W   = 6;
   localparam int unsigned SEC_W   = 6;
   localparam int unsigned SECS_W  = 32;
   localparam int unsigned DAYS_W  = 16;
   localparam int unsigned OPA_W   = 16;
   localparam int unsigned OPB_W   = 17;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_YEAR = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EPOCH_BASE  = 1'd1;

   localparam logic [YEAR_W-1:0] ORIGIN_YEAR_RESET = 7'd0;
   localparam logic [SECS_W-1:0] EPOCH_BASE_RESET  = 32'd946684800;

   localparam logic [OPB_W-1:0] SECS_PER_DAY  = 17'd86400;
   localparam logic [OPB_W-1:0] SECS_PER_HOUR = 17'd3600;
   localparam logic [OPB_W-1:0] SECS_PER_MIN  = 17'd60;
   localparam logic [OPB_W-1:0] SECS_PER_SEC  = 17'd1;

   localparam logic [DAYS_W-1:0] DAYS_LEAP_YEAR = 16'd366;
   localparam logic [DAYS_W-1:0] DAYS_YEAR      = 16'd365;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   // operand pair for the shared multiply-accumulate
   typedef struct packed {
      logic [OPA_W-1:0] op_a;
      logic [OPB_W-1:0] op_b;
   } mac_op_type;

   // gregorian rule on 2000 - 100 * century + y, for y in 0 to 127
   function automatic logic is_leap(logic century, logic [YEAR_W-1:0] y);
      logic div4;
      logic div100;
      logic div400;
      div4   = (y[1:0] == 2'd0);
      div100 = (y == 7'd0) || (y == 7'd100);
      div400 = ((y == 7'd0) && !century) || ((y == 7'd100) && century);
      return div4 && (!div100 || div400);
   endfunction

   function automatic logic [8:0] days_before_month(logic [MONTH_W-1:0] month);
      logic [8:0] d;
      unique case (month)
         4'd1:    d = 9'd0;
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/dtes_mac.sv
`default_nettype none

module dtes_mac
   import dtes_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              load,
   input  wire logic [SECS_W-1:0] load_value,
   input  wire logic              enable,
   input  wire mac_op_type        operands,
   output logic      [SECS_W-1:0] acc
);

   logic [SECS_W-1:0]        acc_ff;
   logic [SECS_W-1:0]        acc_in;
   logic [OPA_W+OPB_W-1:0]   product;

   assign product = {{OPB_W{1'b0}}, operands.op_a} * {{OPA_W{1'b0}}, operands.op_b};

   always_comb begin
      priority if (load) begin
         acc_in = load_value;
      end else if (enable) begin
         acc_in = acc_ff + product[SECS_W-1:0];
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

FILE: rtl/datetime_to_epoch_seconds.sv
`default_nettype none

// Converts a two-digit-year date and time into a 32-bit seconds count that starts
// at the base seconds register on January first of the base year register (within
// the century the word selects). One word at a time: after acceptance the block walks
// the whole years from the base year up to the given year, one year per cycle, then
// runs four steps through a single shared multiply-accumulate unit (days, hours,
// minutes, seconds), and ends in a done state that waits until the output register is
// free; a word with a bad month or a zero day goes straight to the done state. The
// result sits in an output register, so a new word may be accepted while the previous
// result is still stalled. Write the csr registers only while idle.

module datetime_to_epoch_seconds
   import dtes_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,

   input  wire logic                 csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [SECS_W-1:0]    csr_write_data,

   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 req_century_flag,
   input  wire logic [YEAR_W-1:0]    req_year_in_century,
   input  wire logic [MONTH_W-1:0]   req_month_number,
   input  wire logic [DAY_W-1:0]     req_day_of_month,
   input  wire logic [HOUR_W-1:0]    req_hour_of_day,
   input  wire logic [MIN_W-1:0]     req_minute_of_hour,
   input  wire logic [SEC_W-1:0]     req_second_of_minute,

   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [SECS_W-1:0]         rsp_epoch_seconds,
   output logic                      rsp_date_invalid
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_YEAR = 3'd1;
   localparam logic [2:0] ST_MAC  = 3'd2;
   localparam logic [2:0] ST_DONE = 3'd3;

   localparam logic [1:0] MAC_DAYS  = 2'd0;
   localparam logic [1:0] MAC_HOURS = 2'd1;
   localparam logic [1:0] MAC_MINS  = 2'd2;
   localparam logic [1:0] MAC_SECS  = 2'd3;

   logic [2:0]          state_ff, state_in;
   logic [1:0]          step_ff, step_in;
   logic [YEAR_W-1:0]   origin_year_ff, origin_year_in;
   logic [SECS_W-1:0]   epoch_base_ff, epoch_base_in;

   logic                century_ff, century_in;
   logic [YEAR_W-1:0]   year_ff, year_in;
   logic [YEAR_W-1:0]   walk_ff, walk_in;
   logic [DAYS_W-1:0]   days_ff, days_in;
   logic [HOUR_W-1:0]   hour_ff, hour_in;
   logic [MIN_W-1:0]    minute_ff, minute_in;
   logic [SEC_W-1:0]    second_ff, second_in;
   logic                invalid_ff, invalid_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [SECS_W-1:0]   rsp_secs_ff, rsp_secs_in;
   logic                rsp_invalid_ff, rsp_invalid_in;

   logic                req_accept;
   logic                req_bad;
   logic                req_leap_adj;
   logic [DAYS_W-1:0]   req_day_of_year;

   logic                mac_load;
   logic                mac_enable;
   mac_op_type          mac_ops;
   logic [SECS_W-1:0]   mac_acc;

   logic                out_free;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign req_bad = (req_month_number < MONTH_JAN) || (req_month_number > MONTH_DEC) ||
                    (req_day_of_month == '0);
   assign req_leap_adj = (req_month_number > MONTH_FEB) &&
                         is_leap(req_century_flag, req_year_in_century);
   assign req_day_of_year = DAYS_W'(days_before_month(req_month_number))
                          + DAYS_W'(req_day_of_month) - DAYS_W'(1)
                          + DAYS_W'(req_leap_adj);

   always_comb begin
      origin_year_in = origin_year_ff;
      epoch_base_in  = epoch_base_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ORIGIN_YEAR: origin_year_in = csr_write_data[YEAR_W-1:0];
            CSR_EPOCH_BASE:  epoch_base_in = csr_write_data;
            default:         epoch_base_in = epoch_base_ff;
         endcase
      end
   end

   // operand select for the shared multiply-accumulate
   always_comb begin
      unique case (step_ff)
         MAC_DAYS:  mac_ops = '{op_a: days_ff, op_b: SECS_PER_DAY};
         MAC_HOURS: mac_ops = '{op_a: OPA_W'(hour_ff), op_b: SECS_PER_HOUR};
         MAC_MINS:  mac_ops = '{op_a: OPA_W'(minute_ff), op_b: SECS_PER_MIN};
         MAC_SECS:  mac_ops = '{op_a: OPA_W'(second_ff), op_b: SECS_PER_SEC};
         default:   mac_ops = '{op_a: '0, op_b: '0};
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      century_in     = century_ff;
      year_in        = year_ff;
      walk_in        = walk_ff;
      days_in        = days_ff;
      hour_in        = hour_ff;
      minute_in      = minute_ff;
      second_in      = second_ff;
      invalid_in     = invalid_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_secs_in    = rsp_secs_ff;
      rsp_invalid_in = rsp_invalid_ff;
      mac_load       = 1'b0;
      mac_enable     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               century_in = req_century_flag;
               year_in    = req_year_in_century;
               walk_in    = origin_year_ff;
               days_in    = req_day_of_year;
               hour_in    = req_hour_of_day;
               minute_in  = req_minute_of_hour;
               second_in  = req_second_of_minute;
               invalid_in = req_bad;
               state_in   = req_bad ? ST_DONE : ST_YEAR;
            end
         end
         ST_YEAR: begin
            if (walk_ff < year_ff) begin
               days_in = days_ff + (is_leap(century_ff, walk_ff) ? DAYS_LEAP_YEAR : DAYS_YEAR);
               walk_in = walk_ff + YEAR_W'(1);
            end else begin
               mac_load = 1'b1;
               step_in  = MAC_DAYS;
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            mac_enable = 1'b1;
            step_in    = step_ff + 2'd1;
            if (step_ff == MAC_SECS) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_secs_in    = invalid_ff ? '0 : mac_acc;
               rsp_invalid_in = invalid_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   dtes_mac u_mac (
      .clock      (clock),
      .load       (mac_load),
      .load_value (epoch_base_ff),
      .enable     (mac_enable),
      .operands   (mac_ops),
      .acc        (mac_acc)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         step_ff        <= MAC_DAYS;
         origin_year_ff <= ORIGIN_YEAR_RESET;
         epoch_base_ff  <= EPOCH_BASE_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         step_ff        <= step_in;
         origin_year_ff <= origin_year_in;
         epoch_base_ff  <= epoch_base_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      century_ff     <= century_in;
      year_ff        <= year_in;
      walk_ff        <= walk_in;
      days_ff        <= days_in;
      hour_ff        <= hour_in;
      minute_ff      <= minute_in;
      second_ff      <= second_in;
      invalid_ff     <= invalid_in;
      rsp_secs_ff    <= rsp_secs_in;
      rsp_invalid_ff <= rsp_invalid_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_epoch_seconds = rsp_secs_ff;
   assign rsp_date_invalid  = rsp_invalid_ff;

endmodule

`default_nettype wire
